// File: hdl/mvdss_pkg.sv
// ----------------------------------------------------------------------------
// mvdss_pkg
// Shared types, codes and small helper functions of the multi-voice
// delta-coded sample synthesizer.
// ----------------------------------------------------------------------------
package mvdss_pkg;

  // Stream word widths.
  localparam int unsigned S_TDATA_W = 40;
  localparam int unsigned S_TUSER_W = 6;
  localparam int unsigned M_TDATA_W = 48;
  localparam int unsigned M_TUSER_W = 1;

  // Operation codes carried in the input tuser.
  localparam logic [2:0] OP_DATA_WR   = 3'd0;
  localparam logic [2:0] OP_DATA_RD   = 3'd1;
  localparam logic [2:0] OP_CMD_WR    = 3'd2;
  localparam logic [2:0] OP_STATUS_RD = 3'd3;
  localparam logic [2:0] OP_TICK      = 3'd4;

  // Data register indexes.
  localparam logic [1:0] REG_DATA0    = 2'd0;
  localparam logic [1:0] REG_DATA1    = 2'd1;
  localparam logic [1:0] REG_DATA2    = 2'd2;
  localparam logic [1:0] NUM_DATA_REG = 2'd3;

  // Command words and per-voice command codes.
  localparam logic [15:0] CMD_MASTER_GAIN = 16'h0012;
  localparam logic [15:0] CODE_MASK       = 16'h60ff;
  localparam logic [15:0] CODE_START      = 16'h0008;
  localparam logic [15:0] CODE_END        = 16'h0000;
  localparam logic [15:0] CODE_LOOP       = 16'h2000;
  localparam logic [15:0] CODE_SHIFT      = 16'h200a;
  localparam logic [15:0] CODE_KEY        = 16'h200b;
  localparam logic [15:0] CODE_BALANCE    = 16'h4004;
  localparam logic [15:0] CODE_PITCH      = 16'h4005;
  localparam logic [15:0] CODE_GAIN       = 16'h6006;
  localparam logic [15:0] CODE_ENVELOPE   = 16'h6007;
  localparam logic [15:0] CODE_READBACK   = 16'h2028;

  // Mix accumulator width: one voice term is 46 bits, up to 32 voices.
  localparam int unsigned ACC_W = 51;

  // Step enables from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic phase;
    logic adv_a;
    logic adv_b;
    logic adv_c;
    logic env1;
    logic env2;
    logic mul1;
    logic mul2;
    logic mul3;
    logic mul4;
    logic mul5;
    logic acc;
    logic next_voice;
    logic scale1;
    logic scale2;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic [2:0] op;
    logic       voice_on;
    logic       cnt_zero;
    logic       reload;
    logic       last_voice;
  } dp_stat_t;

  // Exponent increment selected by the two low bits of an even ROM word.
  function automatic logic [2:0] exp_inc(input logic [1:0] code);
    logic [2:0] r;
    case (code)
      2'd0:    r = 3'd0;
      2'd1:    r = 3'd1;
      2'd2:    r = 3'd2;
      default: r = 3'd7;
    endcase
    return r;
  endfunction

  // Piecewise envelope rate from the low byte of the envelope word.
  function automatic logic [28:0] env_rate(input logic [7:0] x);
    logic [28:0] xv;
    logic [28:0] r;
    xv = 29'(x);
    if (x >= 8'd127) begin
      r = xv << 21;
    end else if (x >= 8'd63) begin
      r = xv << 16;
    end else if (x >= 8'd47) begin
      r = xv << 14;
    end else if (x >= 8'd31) begin
      r = xv << 11;
    end else if (x >= 8'd23) begin
      r = xv << 9;
    end else if (x >= 8'd15) begin
      r = xv << 7;
    end else begin
      r = xv << 5;
    end
    return r;
  endfunction

endpackage

// File: hdl/mvdss_ctrl.sv
// ----------------------------------------------------------------------------
// mvdss_ctrl
// Sequencer: walks one word through execution, the voice loop of a tick and
// the output register handshake.
// ----------------------------------------------------------------------------
module mvdss_ctrl import mvdss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  logic     m_ready_i,
  output logic     m_valid_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [18:0] {
    ST_IDLE  = 19'h00001,
    ST_EXEC  = 19'h00002,
    ST_VCHK  = 19'h00004,
    ST_PHASE = 19'h00008,
    ST_LOOP  = 19'h00010,
    ST_ADVA  = 19'h00020,
    ST_ADVB  = 19'h00040,
    ST_ADVC  = 19'h00080,
    ST_ENV1  = 19'h00100,
    ST_ENV2  = 19'h00200,
    ST_MUL1  = 19'h00400,
    ST_MUL2  = 19'h00800,
    ST_MUL3  = 19'h01000,
    ST_MUL4  = 19'h02000,
    ST_MUL5  = 19'h04000,
    ST_ACC   = 19'h08000,
    ST_SCL1  = 19'h10000,
    ST_SCL2  = 19'h20000,
    ST_FIN   = 19'h40000
  } state_e;

  state_e state_q, state_d;
  logic   m_valid_q, m_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = (stat_i.op == OP_TICK) ? ST_VCHK : ST_FIN;
      end
      ST_VCHK: begin
        if (stat_i.voice_on) begin
          state_d = ST_PHASE;
        end else if (stat_i.last_voice) begin
          state_d = ST_SCL1;
        end else begin
          cmd_o.next_voice = 1'b1;
        end
      end
      ST_PHASE: begin
        cmd_o.phase = 1'b1;
        state_d     = ST_LOOP;
      end
      ST_LOOP: begin
        state_d = stat_i.cnt_zero ? ST_ENV1 : ST_ADVA;
      end
      ST_ADVA: begin
        cmd_o.adv_a = 1'b1;
        state_d     = ST_ADVB;
      end
      ST_ADVB: begin
        cmd_o.adv_b = 1'b1;
        state_d     = stat_i.reload ? ST_ADVC : ST_LOOP;
      end
      ST_ADVC: begin
        cmd_o.adv_c = 1'b1;
        state_d     = ST_LOOP;
      end
      ST_ENV1: begin
        cmd_o.env1 = 1'b1;
        state_d    = ST_ENV2;
      end
      ST_ENV2: begin
        cmd_o.env2 = 1'b1;
        state_d    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = ST_MUL4;
      end
      ST_MUL4: begin
        cmd_o.mul4 = 1'b1;
        state_d    = ST_MUL5;
      end
      ST_MUL5: begin
        cmd_o.mul5 = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (stat_i.last_voice) begin
          state_d = ST_SCL1;
        end else begin
          cmd_o.next_voice = 1'b1;
          state_d          = ST_VCHK;
        end
      end
      ST_SCL1: begin
        cmd_o.scale1 = 1'b1;
        state_d      = ST_SCL2;
      end
      ST_SCL2: begin
        cmd_o.scale2 = 1'b1;
        state_d      = ST_FIN;
      end
      ST_FIN: begin
        if (!m_valid_q || m_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (cmd_o.load_out) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;

endmodule

// File: hdl/mvdss_dp.sv
// ----------------------------------------------------------------------------
// mvdss_dp
// Datapath: register file, voice state, sample ROM, delta decoder, envelope,
// multiply chain, mix accumulators and output register.
// ----------------------------------------------------------------------------
module mvdss_dp import mvdss_pkg::*; #(
  parameter int VOICES        = 24,
  parameter int ROM_ADDR_BITS = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dp_cmd_t              cmd_i,
  output dp_stat_t             stat_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  input  logic [S_TUSER_W-1:0] s_tuser_i,
  output logic [M_TDATA_W-1:0] m_tdata_o,
  output logic [M_TUSER_W-1:0] m_tuser_o
);

  localparam int AW     = ROM_ADDR_BITS;
  localparam int WAW    = ROM_ADDR_BITS - 1;
  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

  // Input word fields.
  logic [15:0] bus_in;
  logic [19:0] rom_addr_in;
  logic [2:0]  op_in;
  logic [1:0]  ri_in;
  logic        rom_load_in;

  assign bus_in      = s_tdata_i[15:0];
  assign rom_addr_in = s_tdata_i[35:16];
  assign op_in       = s_tuser_i[2:0];
  assign ri_in       = s_tuser_i[4:3];
  assign rom_load_in = s_tuser_i[5];

  logic [2:0]  op_q;
  logic [1:0]  ri_q;
  logic [15:0] bus_q;

  // Register file and voice state.
  logic [15:0]       dreg_q [3];
  logic [5:0]        mg_q;
  logic              on_q    [VOICES];
  logic [AW-1:0]     start_q [VOICES];
  logic [AW-1:0]     end_q   [VOICES];
  logic [AW-1:0]     loop_q  [VOICES];
  logic [AW-1:0]     play_q  [VOICES];
  logic [24:0]       phase_q [VOICES];
  logic [31:0]       rate_q  [VOICES];
  logic [15:0]       cur_q   [VOICES];
  logic [15:0]       delta_q [VOICES];
  logic [2:0]        exp_q   [VOICES];
  logic [30:0]       lvl_q   [VOICES];
  logic [30:0]       goal_q  [VOICES];
  logic [28:0]       estep_q [VOICES];
  logic              fin_q   [VOICES];
  logic [5:0]        pan_q   [VOICES];
  logic [7:0]        gain_q  [VOICES];

  logic [VIDX_W-1:0] vi_q;
  logic [7:0]        cnt_q;
  logic              reload_q;

  // Sample ROM.
  logic [15:0]  rom_mem [2**WAW];
  logic [15:0]  rom_rd_q;
  logic [WAW-1:0] raddr;

  // Arithmetic pipeline registers.
  logic signed [31:0]      diff_q;
  logic signed [19:0]      ip_q;
  logic [13:0]             env2_q;
  logic signed [17:0]      s_q;
  logic signed [26:0]      sg_q;
  logic signed [41:0]      sge_q;
  logic signed [45:0]      pl_q, pr_q;
  logic signed [ACC_W-1:0] accl_q, accr_q;
  logic signed [57:0]      scl_l_q, scl_r_q;
  logic [15:0]             lc_q, rc_q;
  logic [M_TDATA_W-1:0]    m_tdata_q;
  logic [M_TUSER_W-1:0]    m_tuser_q;

  // Command decode.
  logic [15:0]       code;
  logic [4:0]        vn;
  logic              vn_ok;
  logic [VIDX_W-1:0] cn;
  logic              key_on;
  logic              env_fin;

  assign code    = bus_q & CODE_MASK;
  assign vn      = bus_q[12:8];
  assign vn_ok   = ({27'd0, vn} < 32'(VOICES));
  assign cn      = VIDX_W'(vn);
  assign key_on  = dreg_q[REG_DATA2][7];
  assign env_fin = dreg_q[REG_DATA0][15];

  // Current tick voice.
  logic [AW-1:0]      play_c, loop_c, end_c, end_p1, tab_addr, tab10, play_p1;
  logic               reload_now, wrap_end;
  logic [32:0]        psum;
  logic [6:0]         d7;
  logic [2:0]         exp_nx;
  logic signed [15:0] d16, delta_nx;
  logic signed [15:0] cur_c, delta_c;
  logic [31:0]        ndiff;
  logic signed [19:0] ip_d, ipb;
  logic signed [16:0] q17;
  logic [6:0]         env_c;

  always_comb begin
    play_c     = play_q[vi_q];
    loop_c     = loop_q[vi_q];
    end_c      = end_q[vi_q];
    end_p1     = end_c + AW'(1);
    tab_addr   = {end_p1[AW-1:1], 1'b0};
    tab10      = tab_addr + AW'(10);
    reload_now = (play_c == {loop_c[AW-1:1], 1'b1});
    play_p1    = play_c + AW'(1);
    wrap_end   = (play_p1 == end_c);
    psum       = 33'(phase_q[vi_q]) + 33'(rate_q[vi_q]);
    cur_c      = $signed(cur_q[vi_q]);
    delta_c    = $signed(delta_q[vi_q]);
    d7         = play_c[0] ? rom_rd_q[15:9] : rom_rd_q[8:2];
    exp_nx     = play_c[0] ? exp_q[vi_q] : (exp_q[vi_q] + exp_inc(rom_rd_q[1:0]));
    d16        = $signed({{9{d7[6]}}, d7});
    delta_nx   = d16 <<< exp_nx;
    ndiff      = 32'(-diff_q);
    ip_d       = delta_c * $signed({1'b0, phase_q[vi_q][24:22]});
    ipb        = ip_q + (ip_q[19] ? 20'sd7 : 20'sd0);
    q17        = ipb[19:3];
    env_c      = lvl_q[vi_q][30:24];
    if (cmd_i.adv_b) begin
      raddr = tab10[AW-1:1];
    end else if (reload_now) begin
      raddr = tab_addr[AW-1:1];
    end else begin
      raddr = play_c[AW-1:1];
    end
  end

  function automatic logic [15:0] sat16(input logic signed [31:0] r);
    logic [15:0] v;
    if (r > 32'sd32767) begin
      v = 16'h7fff;
    end else if (r < -32'sd32768) begin
      v = 16'h8000;
    end else begin
      v = r[15:0];
    end
    return v;
  endfunction

  // ROM port: one write on an accepted load, one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch && rom_load_in) begin
      rom_mem[WAW'(rom_addr_in)] <= bus_in;
    end
    rom_rd_q <= rom_mem[raddr];
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        dreg_q[i] <= '0;
      end
      mg_q     <= '0;
      vi_q     <= '0;
      cnt_q    <= '0;
      reload_q <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        on_q[i]    <= 1'b0;
        start_q[i] <= '0;
        end_q[i]   <= '0;
        loop_q[i]  <= '0;
        play_q[i]  <= '0;
        phase_q[i] <= '0;
        rate_q[i]  <= '0;
        cur_q[i]   <= '0;
        delta_q[i] <= '0;
        exp_q[i]   <= '0;
        lvl_q[i]   <= '0;
        goal_q[i]  <= '0;
        estep_q[i] <= '0;
        fin_q[i]   <= 1'b0;
        pan_q[i]   <= '0;
        gain_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.exec) begin
        case (op_q)
          OP_DATA_WR: begin
            if (ri_q < NUM_DATA_REG) begin
              dreg_q[ri_q] <= bus_q;
            end
          end
          OP_TICK: begin
            vi_q <= '0;
          end
          OP_CMD_WR: begin
            if (bus_q == CMD_MASTER_GAIN) begin
              mg_q <= dreg_q[REG_DATA0][5:0];
            end else if (vn_ok) begin
              case (code)
                CODE_START: begin
                  start_q[cn] <= AW'({dreg_q[REG_DATA2], dreg_q[REG_DATA1][15:1], 1'b0});
                end
                CODE_END: begin
                  end_q[cn] <= AW'({dreg_q[REG_DATA1], dreg_q[REG_DATA0]});
                end
                CODE_LOOP: begin
                  loop_q[cn] <= AW'({dreg_q[REG_DATA1], dreg_q[REG_DATA0]});
                end
                CODE_SHIFT: begin
                  exp_q[cn] <= dreg_q[REG_DATA2][2:0];
                end
                CODE_KEY: begin
                  if (key_on && !on_q[cn]) begin
                    play_q[cn]  <= start_q[cn];
                    phase_q[cn] <= '0;
                    cur_q[cn]   <= '0;
                  end
                  on_q[cn]  <= key_on;
                  fin_q[cn] <= fin_q[cn] && key_on;
                end
                CODE_BALANCE: begin
                  pan_q[cn] <= dreg_q[REG_DATA1][7:2];
                end
                CODE_PITCH: begin
                  rate_q[cn] <= {dreg_q[REG_DATA1][7:0], dreg_q[REG_DATA0],
                                 dreg_q[REG_DATA1][15:8]};
                end
                CODE_GAIN: begin
                  gain_q[cn] <= dreg_q[REG_DATA1][7:0];
                end
                CODE_ENVELOPE: begin
                  if (!fin_q[cn] || env_fin) begin
                    fin_q[cn]   <= env_fin;
                    goal_q[cn]  <= {dreg_q[REG_DATA0][14:8], 24'd0};
                    estep_q[cn] <= env_rate(dreg_q[REG_DATA0][7:0]);
                  end
                end
                CODE_READBACK: begin
                  dreg_q[REG_DATA0] <= on_q[cn] ? {1'b0, lvl_q[cn][30:16]} : 16'd0;
                  dreg_q[REG_DATA1] <= cur_q[cn];
                end
                default: begin
                end
              endcase
            end
          end
          default: begin
          end
        endcase
      end

      if (cmd_i.next_voice) begin
        vi_q <= vi_q + VIDX_W'(1);
      end

      if (cmd_i.phase) begin
        phase_q[vi_q] <= psum[24:0];
        cnt_q         <= psum[32:25];
      end

      if (cmd_i.adv_a) begin
        cnt_q        <= cnt_q - 8'd1;
        reload_q     <= reload_now;
        cur_q[vi_q]  <= cur_q[vi_q] + delta_q[vi_q];
      end

      if (cmd_i.adv_b) begin
        if (reload_q) begin
          delta_q[vi_q] <= rom_rd_q - cur_q[vi_q];
        end else begin
          exp_q[vi_q]   <= exp_nx;
          delta_q[vi_q] <= delta_nx;
        end
      end

      if ((cmd_i.adv_b && !reload_q) || cmd_i.adv_c) begin
        if (cmd_i.adv_c) begin
          exp_q[vi_q] <= rom_rd_q[2:0];
        end
        if (wrap_end) begin
          play_q[vi_q] <= loop_c;
          if (loop_c == end_c) begin
            on_q[vi_q] <= 1'b0;
          end
        end else begin
          play_q[vi_q] <= play_p1;
        end
      end

      if (cmd_i.env2) begin
        if (!diff_q[31] && (diff_q != 32'sd0) && ($unsigned(diff_q) > 32'(estep_q[vi_q])))
        begin
          lvl_q[vi_q] <= lvl_q[vi_q] + 31'(estep_q[vi_q]);
        end else if (diff_q[31] && (ndiff > 32'(estep_q[vi_q]))) begin
          lvl_q[vi_q] <= lvl_q[vi_q] - 31'(estep_q[vi_q]);
        end else begin
          lvl_q[vi_q] <= goal_q[vi_q];
        end
      end
    end
  end

  // Payload and arithmetic pipeline.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= op_in;
      ri_q  <= ri_in;
      bus_q <= bus_in;
    end
    if (cmd_i.exec && (op_q == OP_TICK)) begin
      accl_q <= '0;
      accr_q <= '0;
    end
    if (cmd_i.env1) begin
      diff_q <= $signed({1'b0, goal_q[vi_q]}) - $signed({1'b0, lvl_q[vi_q]});
    end
    if (cmd_i.mul1) begin
      ip_q   <= ip_d;
      env2_q <= {7'd0, env_c} * {7'd0, env_c};
    end
    if (cmd_i.mul2) begin
      s_q <= {{2{cur_c[15]}}, cur_c} + {q17[16], q17};
    end
    if (cmd_i.mul3) begin
      sg_q <= s_q * $signed({1'b0, gain_q[vi_q]});
    end
    if (cmd_i.mul4) begin
      sge_q <= sg_q * $signed({1'b0, env2_q});
    end
    if (cmd_i.mul5) begin
      pl_q <= sge_q * $signed({1'b0, pan_q[vi_q][5:3]});
      pr_q <= sge_q * $signed({1'b0, pan_q[vi_q][2:0]});
    end
    if (cmd_i.acc) begin
      accl_q <= accl_q + {{(ACC_W - 46){pl_q[45]}}, pl_q};
      accr_q <= accr_q + {{(ACC_W - 46){pr_q[45]}}, pr_q};
    end
    if (cmd_i.scale1) begin
      scl_l_q <= accl_q * $signed({1'b0, mg_q});
      scl_r_q <= accr_q * $signed({1'b0, mg_q});
    end
    if (cmd_i.scale2) begin
      lc_q <= sat16(scl_l_q[57:26]);
      rc_q <= sat16(scl_r_q[57:26]);
    end
    if (cmd_i.load_out) begin
      if (op_q == OP_TICK) begin
        m_tdata_q <= {rc_q, lc_q, 16'd0};
        m_tuser_q <= 1'b1;
      end else begin
        m_tuser_q <= 1'b0;
        if ((op_q == OP_DATA_RD) && (ri_q < NUM_DATA_REG)) begin
          m_tdata_q <= {32'd0, dreg_q[ri_q]};
        end else if (op_q == OP_STATUS_RD) begin
          m_tdata_q <= {42'd0, mg_q};
        end else begin
          m_tdata_q <= '0;
        end
      end
    end
  end

  assign stat_o.op         = op_q;
  assign stat_o.voice_on   = on_q[vi_q];
  assign stat_o.cnt_zero   = (cnt_q == 8'd0);
  assign stat_o.reload     = reload_q;
  assign stat_o.last_voice = (vi_q == VIDX_W'(VOICES - 1));

  assign m_tdata_o = m_tdata_q;
  assign m_tuser_o = m_tuser_q;

endmodule

// File: hdl/multi_voice_delta_sample_synth_top.sv
// ----------------------------------------------------------------------------
// multi_voice_delta_sample_synth_top
// Multi-voice sample playback synthesizer with delta-coded sample ROM.
// ----------------------------------------------------------------------------
// Usage: each input word on the s_axis channel is one bus operation: a data
// register write or read, a command write, a status read or a sample tick.
// A word may also load one sample ROM entry; the load takes effect before
// the operation in the same word. Every input word yields exactly one output
// word on m_axis, carrying read data, the left and right mixed samples and a
// flag that marks a tick.
// Flow: one word is worked on at a time. Register and command words go
// from the execute state to the output load. A tick walks the voices in turn;
// each active voice fetches its ROM deltas through the single ROM read port
// and passes through the shared multiply chain, and the mix is then scaled.
// Reset clears all voice state, the data registers and the master gain; the
// sample ROM keeps its contents and must be written before it is read.
// A result waits in the output register while the receiver stalls; the next
// input word is still accepted and worked on, and its result is held back
// until the output register is free.
// ----------------------------------------------------------------------------
module multi_voice_delta_sample_synth_top import mvdss_pkg::*; #(
  parameter int VOICES        = 24,
  parameter int ROM_ADDR_BITS = 21
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: bus_data[15:0], rom_address[35:16], zero [39:36]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // tuser: op[2:0], reg_index[4:3], rom_load[5]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // tdata: read_data[15:0], left_out[31:16], right_out[47:32]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // tuser: sample_valid[0]
  output logic [M_TUSER_W-1:0] m_axis_tuser
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer for operations and the per-voice tick loop.
  mvdss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // Registers, voice state, sample ROM and mixing arithmetic.
  mvdss_dp #(
    .VOICES        (VOICES),
    .ROM_ADDR_BITS (ROM_ADDR_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .s_tdata_i (s_axis_tdata),
    .s_tuser_i (s_axis_tuser),
    .m_tdata_o (m_axis_tdata),
    .m_tuser_o (m_axis_tuser)
  );

endmodule
